>>> rtl/core/c128b_pkg.sv
package c128b_pkg;

    // Input word: one message byte and its end marker
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_word_t;

    // Output word: one Code 128 symbol
    typedef struct packed {
        logic [12:0] pattern;
        logic [3:0]  module_count;
        logic [6:0]  symbol_value;
        logic        bad_char;
        logic        end_of_run;
        logic        end_of_message;
    } sym_word_t;

    // Check pipeline to symbol sequencer: one character with its context
    typedef struct packed {
        logic [6:0] value;
        logic       bad;
        logic       first;
        logic       last;
        logic [6:0] check;
    } chk_word_t;

    // Symbol kinds within the run caused by one character
    typedef enum logic [1:0] {
        KIND_START,
        KIND_CHAR,
        KIND_CHECK,
        KIND_STOP
    } sym_kind_t;

    localparam logic [6:0] SYM_START_B   = 7'd104;
    localparam logic [6:0] SYM_STOP      = 7'd106;
    localparam logic [6:0] CHECK_MOD     = 7'd103;
    localparam logic [6:0] START_RESIDUE = 7'(104 % 103);
    localparam logic [7:0] SET_B_BASE    = 8'h20;
    localparam logic [3:0] SYM_MODULES   = 4'd11;
    localparam logic [3:0] STOP_MODULES  = 4'd13;
    localparam int         NUM_SYMBOLS   = 106;

    // Element widths, bar first, one nibble each, first element in bits 23:20
    localparam logic [23:0] SYM_WIDTHS [NUM_SYMBOLS] = '{
        24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222,
        24'h122213, 24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212,
        24'h112232, 24'h122132, 24'h122231, 24'h113222, 24'h123122, 24'h123221,
        24'h223211, 24'h221132, 24'h221231, 24'h213212, 24'h223112, 24'h312131,
        24'h311222, 24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
        24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123, 24'h131321,
        24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
        24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121,
        24'h313121, 24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131,
        24'h311123, 24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
        24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422, 24'h121124,
        24'h121421, 24'h141122, 24'h141221, 24'h112214, 24'h112412, 24'h122114,
        24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114, 24'h413111,
        24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
        24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
        24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113,
        24'h114311, 24'h411113, 24'h411311, 24'h113141, 24'h114131, 24'h311141,
        24'h411131, 24'h211412, 24'h211214, 24'h211232
    };

    // Stop symbol: seven elements, 13 modules
    localparam logic [27:0] STOP_WIDTHS = 28'h2331112;

    // Expand seven width nibbles (first in bits 27:24) into module bits, bar first
    function automatic logic [12:0] build_pattern(logic [27:0] widths);
        logic [12:0] pat;
        logic [3:0]  w;
        logic        bar;
        pat = '0;
        bar = 1'b1;
        for (int i = 6; i >= 0; i--)
        begin
            w   = widths[4*i +: 4];
            pat = (pat << w) | (bar ? ~(13'h1FFF << w) : 13'h0000);
            bar = ~bar;
        end
        return pat;
    endfunction

    // Module pattern of a symbol value; six-element symbols get an empty seventh
    function automatic logic [12:0] symbol_pattern(logic [6:0] value);
        logic [12:0] pat;
        if (value == SYM_STOP)
            pat = build_pattern(STOP_WIDTHS);
        else if (value < 7'(NUM_SYMBOLS))
            pat = build_pattern({SYM_WIDTHS[value], 4'h0});
        else
            pat = '0;
        return pat;
    endfunction

endpackage

>>> rtl/core/c128b_check_pipe.sv
module c128b_check_pipe
    import c128b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_word_t char_word,
    output logic       chk_valid,
    input  logic       chk_ready,
    output chk_word_t  chk_word
);

    // Stage registers
    logic       s1_vld_reg, s1_vld_next;
    char_word_t s1_word_reg;
    logic       s2_vld_reg, s2_vld_next;
    logic [6:0] s2_value_reg;
    logic       s2_bad_reg;
    logic       s2_first_reg;
    logic       s2_last_reg;
    logic [13:0] s2_prod_reg;
    logic       s3_vld_reg, s3_vld_next;
    chk_word_t  s3_word_reg;

    // Message state
    logic       open_reg, open_next;
    logic [6:0] pos_reg, pos_next;
    logic [6:0] acc_reg, acc_next;

    logic       char_accept;
    logic       s3_take, s2_take, s2_adv, s1_adv;
    logic       s1_bad;
    logic [6:0] s1_value;
    logic [6:0] s1_pos;
    logic [13:0] s1_prod;
    logic [6:0] s2_prod_mod;
    logic [6:0] s2_base;
    logic [7:0] s2_sum;
    logic [6:0] s2_check;

    // Fold a position product (at most 102*95) down to its residue modulo 103 (128 = 25 mod 103)
    function automatic logic [6:0] mod103(logic [13:0] p);
        logic [10:0] t1;
        logic [8:0]  t2;
        logic [7:0]  t3;
        logic [7:0]  r;
        t1 = 11'(p[13:7]) * 11'd25 + 11'(p[6:0]);
        t2 = 9'(t1[10:7]) * 9'd25 + 9'(t1[6:0]);
        t3 = 8'(t2[8:7]) * 8'd25 + 8'(t2[6:0]);
        r  = (t3 >= 8'(CHECK_MOD)) ? t3 - 8'(CHECK_MOD) : t3;
        return r[6:0];
    endfunction

    // Handshake: each stage refills as soon as its content moves on
    assign s3_take     = !s3_vld_reg || chk_ready;
    assign s2_take     = !s2_vld_reg || s3_take;
    assign s2_adv      = s2_vld_reg && s3_take;
    assign s1_adv      = s1_vld_reg && s2_take;
    assign char_ready  = !s1_vld_reg || s2_take;
    assign char_accept = char_valid && char_ready;

    // Stage 1: set B value and position product
    always_comb
    begin
        s1_bad   = s1_word_reg.character[7] || (s1_word_reg.character < SET_B_BASE);
        s1_value = s1_bad ? 7'd0 : 7'(s1_word_reg.character - SET_B_BASE);
        s1_pos   = (pos_reg == CHECK_MOD - 7'd1) ? 7'd0 : pos_reg + 7'd1;
        s1_prod  = 14'(s1_pos) * 14'(s1_value);
    end

    // Stage 2: running check sum modulo 103
    always_comb
    begin
        s2_prod_mod = mod103(s2_prod_reg);
        s2_base     = s2_first_reg ? START_RESIDUE : acc_reg;
        s2_sum      = 8'(s2_base) + 8'(s2_prod_mod);
        s2_check    = (s2_sum >= 8'(CHECK_MOD)) ? 7'(s2_sum - 8'(CHECK_MOD)) : s2_sum[6:0];
    end

    // Next control and message state
    always_comb
    begin
        s1_vld_next = char_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
        s2_vld_next = s2_take ? s1_vld_reg : s2_vld_reg;
        s3_vld_next = s3_take ? s2_vld_reg : s3_vld_reg;
        open_next   = open_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        if (s1_adv)
        begin
            open_next = !s1_word_reg.last_char;
            pos_next  = s1_word_reg.last_char ? 7'd0 : s1_pos;
        end
        if (s2_adv)
            acc_next = s2_last_reg ? 7'd0 : s2_check;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            open_reg   <= 1'b0;
            pos_reg    <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
            open_reg   <= open_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (char_accept)
            s1_word_reg <= char_word;
        if (s1_adv)
        begin
            s2_value_reg <= s1_value;
            s2_bad_reg   <= s1_bad;
            s2_first_reg <= !open_reg;
            s2_last_reg  <= s1_word_reg.last_char;
            s2_prod_reg  <= s1_prod;
        end
        if (s2_adv)
        begin
            s3_word_reg.value <= s2_value_reg;
            s3_word_reg.bad   <= s2_bad_reg;
            s3_word_reg.first <= s2_first_reg;
            s3_word_reg.last  <= s2_last_reg;
            s3_word_reg.check <= s2_check;
        end
    end

    assign chk_valid = s3_vld_reg;
    assign chk_word  = s3_word_reg;

endmodule

>>> rtl/core/code128b_symbol_encoder.sv
// Path: an accepted character passes the stage 1, 2 and 3 registers, then the output
//   register; more symbols of the same run follow one per cycle while sym_ready holds.
// Throughput: one character per cycle while each character gives a single symbol and
//   the output is not stalled; a character gives one to four symbols and holds the sequencer.
// Reset: rst_n is asynchronous, active low; it empties the pipeline and closes any message.
module code128b_symbol_encoder
    import c128b_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_word_t char_word,
    output logic       sym_valid,
    input  logic       sym_ready,
    output sym_word_t  sym_word
);

    logic       chk_valid;
    logic       chk_ready;
    chk_word_t  chk_word;

    logic [1:0] idx_reg, idx_next;
    logic       out_vld_reg, out_vld_next;
    sym_word_t  out_word_reg;
    sym_word_t  out_word_next;

    sym_kind_t  kind;
    logic [1:0] offs;
    logic       final_sym;
    logic       emit;

    c128b_check_pipe u_check_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word),
        .chk_valid  (chk_valid),
        .chk_ready  (chk_ready),
        .chk_word   (chk_word)
    );

    // Which symbol of the run comes next
    always_comb
    begin
        offs = idx_reg - {1'b0, chk_word.first};
        if (chk_word.first && (idx_reg == 2'd0))
            kind = KIND_START;
        else
        begin
            case (offs)
                2'd0:    kind = KIND_CHAR;
                2'd1:    kind = KIND_CHECK;
                default: kind = KIND_STOP;
            endcase
        end
        final_sym = chk_word.last ? (kind == KIND_STOP) : (kind == KIND_CHAR);
    end

    // Sequencer handshake: the character word leaves with its last symbol
    assign emit      = chk_valid && (!out_vld_reg || sym_ready);
    assign chk_ready = emit && final_sym;

    // Symbol word for the output register
    always_comb
    begin
        out_word_next                = '0;
        out_word_next.module_count   = SYM_MODULES;
        out_word_next.end_of_run     = final_sym;
        unique case (kind)
            KIND_START: out_word_next.symbol_value = SYM_START_B;
            KIND_CHAR:
            begin
                out_word_next.symbol_value = chk_word.value;
                out_word_next.bad_char     = chk_word.bad;
            end
            KIND_CHECK: out_word_next.symbol_value = chk_word.check;
            KIND_STOP:
            begin
                out_word_next.symbol_value   = SYM_STOP;
                out_word_next.module_count   = STOP_MODULES;
                out_word_next.end_of_message = 1'b1;
            end
            default:    out_word_next.symbol_value = SYM_START_B;
        endcase
        out_word_next.pattern = symbol_pattern(out_word_next.symbol_value);
    end

    // Next control state
    always_comb
    begin
        idx_next     = idx_reg;
        out_vld_next = out_vld_reg;
        if (emit)
        begin
            idx_next     = final_sym ? 2'd0 : idx_reg + 2'd1;
            out_vld_next = 1'b1;
        end
        else if (sym_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_word_reg <= out_word_next;
    end

    assign sym_valid = out_vld_reg;
    assign sym_word  = out_word_reg;

`ifndef SYNTHESIS
    // Stop word closes the run and is the only 13-module word
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_word.end_of_message |->
            sym_word.end_of_run && (sym_word.module_count == STOP_MODULES))
        else $error("stop word malformed");

    // Out-of-set characters go out as value 0 in a normal symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_word.bad_char |->
            (sym_word.symbol_value == 7'd0) && (sym_word.module_count == SYM_MODULES))
        else $error("bad character not encoded as value 0");

    // Check residue reaching the sequencer is reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid |-> (chk_word.check < CHECK_MOD))
        else $error("check residue out of range");

    // A middle character never runs past its own symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid && !chk_word.last |-> (idx_reg <= {1'b0, chk_word.first}))
        else $error("sequencer overran a middle character");

    // Sequencer restarts after each finished run
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_ready |=> (idx_reg == 2'd0))
        else $error("sequencer index not cleared");
`endif

endmodule
